FILE: design/coprime_sum_up_to_n_core_defines.svh
// Assertion macros shared by the checker of the coprime sum core.
`ifndef COPRIME_SUM_UP_TO_N_CORE_DEFINES_SVH
`define COPRIME_SUM_UP_TO_N_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define CSN_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled in reset.
`define CSN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: design/csn_pkg.sv
// Shared types for the coprime sum core.
package csn_pkg;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_req_t;

endpackage

FILE: design/coprime_sum_up_to_n_core.sv
// Top level of the coprime sum core: sequencer around the shared serial unit.
//
//  channel  signals                      direction
//  input    in_valid, in_ready, n_value  item in
//  output   out_valid, out_ready,        item out
//           coprime_sum
//
// An item runs trial divisions up to the square root of n, and per subset of the prime
// factors one divide, two multiplies and one more multiply per prime in the subset,
// with a scan over the primes, all on the single serial multiply and divide unit;
// n of zero goes straight to the result.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
// The result register lets the next item start while a result waits to be taken.
module coprime_sum_up_to_n_core #(
	parameter int INPUT_BITS = 32,
	parameter int MAX_PRIMES = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] n_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [62:0] coprime_sum
);
	localparam int IB  = INPUT_BITS;
	localparam int MP  = MAX_PRIMES;
	localparam int PW  = $clog2(MP + 1);
	localparam int IXW = $clog2(MP);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_TDIV  = 10'b0000000010,
		ST_IE    = 10'b0000000100,
		ST_PSCAN = 10'b0000001000,
		ST_PMUL  = 10'b0000010000,
		ST_MDIV  = 10'b0000100000,
		ST_MSQ   = 10'b0001000000,
		ST_MTERM = 10'b0010000000,
		ST_FMUL  = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	state_t             state_q;
	csn_pkg::alu_req_t  req_q;
	logic [63:0]        opa_q;
	logic [IB:0]        opb_q;
	logic               alu_done;
	logic [63:0]        alu_prod;
	logic [IB-1:0]      alu_quo;
	logic [IB-1:0]      alu_rem;
	logic [IB-1:0]      n_q;
	logic [IB-1:0]      rest_q;
	logic [IB-1:0]      cand_q;
	logic               inner_q;
	logic [PW-1:0]      cnt_q;
	logic [IB-1:0]      primes_q [MP];
	logic [MP:0]        mask_q;
	logic [PW-1:0]      k_q;
	logic               odd_q;
	logic [IB-1:0]      prod_q;
	logic [63:0]        total_q;
	logic [63:0]        sum_q;
	logic               out_valid_q;
	logic [62:0]        out_sum_q;
	logic [MP:0]        limit;
	logic [IB-1:0]      n_in;

	assign n_in  = n_value[IB-1:0];
	assign limit = (MP + 1)'(1) << cnt_q;

	csn_alu #(.IB(IB)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.opa    (opa_q),
		.opb    (opb_q),
		.done   (alu_done),
		.prod   (alu_prod),
		.quo    (alu_quo),
		.rem    (alu_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= '{start: 1'b0, op: csn_pkg::OP_MUL};
			out_valid_q <= 1'b0;
		end else begin
			req_q.start <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (n_in == '0) begin
							state_q <= ST_OUT;
						end else begin
							req_q   <= '{start: 1'b1, op: csn_pkg::OP_DIV};
							state_q <= ST_TDIV;
						end
					end
				end
				ST_TDIV: begin
					if (alu_done) begin
						state_q <= (!inner_q && cand_q > alu_quo) ? ST_IE : ST_TDIV;
						if (inner_q || cand_q <= alu_quo) begin
							req_q <= '{start: 1'b1, op: csn_pkg::OP_DIV};
						end
					end
				end
				ST_IE: begin
					if (mask_q == limit) begin
						req_q   <= '{start: 1'b1, op: csn_pkg::OP_MUL};
						state_q <= ST_FMUL;
					end else begin
						state_q <= ST_PSCAN;
					end
				end
				ST_PSCAN: begin
					if (k_q == cnt_q) begin
						req_q   <= '{start: 1'b1, op: csn_pkg::OP_DIV};
						state_q <= ST_MDIV;
					end else if (mask_q[k_q]) begin
						req_q   <= '{start: 1'b1, op: csn_pkg::OP_MUL};
						state_q <= ST_PMUL;
					end
				end
				ST_PMUL: begin
					if (alu_done) begin
						state_q <= ST_PSCAN;
					end
				end
				ST_MDIV: begin
					if (alu_done) begin
						req_q   <= '{start: 1'b1, op: csn_pkg::OP_MUL};
						state_q <= ST_MSQ;
					end
				end
				ST_MSQ: begin
					if (alu_done) begin
						req_q   <= '{start: 1'b1, op: csn_pkg::OP_MUL};
						state_q <= ST_MTERM;
					end
				end
				ST_MTERM: begin
					if (alu_done) begin
						state_q <= ST_IE;
					end
				end
				ST_FMUL: begin
					if (alu_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q     <= n_in;
				rest_q  <= n_in;
				cand_q  <= IB'(2);
				inner_q <= 1'b0;
				cnt_q   <= '0;
				total_q <= '0;
				sum_q   <= '0;
				opa_q   <= 64'(n_in);
				opb_q   <= (IB + 1)'(2);
			end
			ST_TDIV: begin
				if (alu_done) begin
					if (!inner_q && cand_q > alu_quo) begin
						if (rest_q != IB'(1) && cnt_q < PW'(MP)) begin
							primes_q[cnt_q[IXW-1:0]] <= rest_q;
							cnt_q <= cnt_q + PW'(1);
						end
						mask_q <= (MP + 1)'(1);
					end else if (alu_rem == '0) begin
						if (!inner_q && cnt_q < PW'(MP)) begin
							primes_q[cnt_q[IXW-1:0]] <= cand_q;
							cnt_q <= cnt_q + PW'(1);
						end
						rest_q  <= alu_quo;
						inner_q <= 1'b1;
						opa_q   <= 64'(alu_quo);
						opb_q   <= {1'b0, cand_q};
					end else begin
						cand_q  <= cand_q + IB'(1);
						inner_q <= 1'b0;
						opa_q   <= 64'(rest_q);
						opb_q   <= {1'b0, cand_q + IB'(1)};
					end
				end
			end
			ST_IE: begin
				prod_q <= IB'(1);
				k_q    <= '0;
				odd_q  <= 1'b0;
				opa_q  <= 64'(n_q);
				opb_q  <= (IB + 1)'(n_q) + (IB + 1)'(1);
			end
			ST_PSCAN: begin
				if (k_q == cnt_q) begin
					opa_q <= 64'(n_q);
					opb_q <= {1'b0, prod_q};
				end else begin
					k_q <= k_q + PW'(1);
					if (mask_q[k_q]) begin
						odd_q <= ~odd_q;
						opa_q <= 64'(prod_q);
						opb_q <= {1'b0, primes_q[k_q[IXW-1:0]]};
					end
				end
			end
			ST_PMUL: begin
				if (alu_done) begin
					prod_q <= alu_prod[IB-1:0];
				end
			end
			ST_MDIV: begin
				if (alu_done) begin
					opa_q <= 64'(alu_quo);
					opb_q <= (IB + 1)'(alu_quo) + (IB + 1)'(1);
				end
			end
			ST_MSQ: begin
				if (alu_done) begin
					opa_q <= alu_prod >> 1;
					opb_q <= {1'b0, prod_q};
				end
			end
			ST_MTERM: begin
				if (alu_done) begin
					total_q <= odd_q ? total_q + alu_prod : total_q - alu_prod;
					mask_q  <= mask_q + (MP + 1)'(1);
				end
			end
			ST_FMUL: begin
				if (alu_done) begin
					sum_q <= (alu_prod >> 1) - total_q;
				end
			end
			ST_OUT: begin
				if (!out_valid_q) begin
					out_sum_q <= sum_q[62:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign coprime_sum = out_sum_q;

endmodule

FILE: design/csn_alu.sv
// Shared serial unit: shift-add multiply or restoring divide, one bit a cycle.
module csn_alu #(
	parameter int IB = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  csn_pkg::alu_req_t req,
	input  logic [63:0]       opa,
	input  logic [IB:0]       opb,
	output logic              done,
	output logic [63:0]       prod,
	output logic [IB-1:0]     quo,
	output logic [IB-1:0]     rem
);
	localparam int CW = $clog2(IB + 2);

	logic           busy_q;
	logic           done_q;
	csn_pkg::op_t   op_q;
	logic [CW-1:0]  cnt_q;
	logic [63:0]    acc_q;
	logic [63:0]    x_q;
	logic [IB:0]    y_q;
	logic [IB:0]    tr;
	logic           ge;

	assign tr = {acc_q[IB-1:0], x_q[IB-1]};
	assign ge = tr >= {1'b0, y_q[IB-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == csn_pkg::OP_MUL) ? CW'(IB + 1) : CW'(IB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			acc_q <= '0;
			x_q   <= opa;
			y_q   <= opb;
		end else if (busy_q) begin
			if (op_q == csn_pkg::OP_MUL) begin
				if (y_q[0]) begin
					acc_q <= acc_q + x_q;
				end
				x_q <= {x_q[62:0], 1'b0};
				y_q <= {1'b0, y_q[IB:1]};
			end else begin
				acc_q <= 64'(ge ? tr - {1'b0, y_q[IB-1:0]} : tr);
				x_q   <= {x_q[62:0], ge};
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;
	assign quo  = x_q[IB-1:0];
	assign rem  = acc_q[IB-1:0];

endmodule

FILE: design/coprime_sum_up_to_n_core_checker.sv
// Port-level checker for the coprime sum core, bound to the top level.
`include "coprime_sum_up_to_n_core_defines.svh"

module coprime_sum_up_to_n_core_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [62:0] coprime_sum
);
	// A waiting result item stays put until it is taken.
	`CSN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(coprime_sum))
	// The core is busy for at least the cycle after it takes an item.
	`CSN_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// A new result appears as the core returns to idle from a busy spell.
	`CSN_ASSERT_NOW(a_result_ends_busy, $rose(out_valid), in_ready && $past(!in_ready))

endmodule

bind coprime_sum_up_to_n_core coprime_sum_up_to_n_core_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.coprime_sum (coprime_sum)
);
